/* rtl/eclog_pkg.sv */
// Shared types, constants and helper functions of the circular log block.
// Used by eclog_ctrl, eclog_datapath and the top level; depends on nothing.
`default_nettype none

package eclog_pkg;

    // Byte store geometry and record layout.
    localparam int STORE_BYTES    = 1024;
    localparam int AW             = $clog2(STORE_BYTES);
    localparam int CRC_BYTES      = 2;
    localparam int MAX_USER_BYTES = 64;
    localparam logic [31:0] FILLER_WORD = 32'hddff_ffff;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_READ   = 2'd1,
        CMD_APPEND = 2'd2,
        CMD_RESCAN = 2'd3
    } t_cmd;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SLOT_BEGIN    = 3'd0;
    localparam logic [2:0] CFG_SLOT_LENGTH   = 3'd1;
    localparam logic [2:0] CFG_USER_BYTES    = 3'd2;
    localparam logic [2:0] CFG_COUNTER_BYTES = 3'd3;
    localparam logic [2:0] CFG_COUNTER_MAX   = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the accepted command
        logic clr_wr;     // erase one byte during the clearing pass
        logic raw_wr;     // raw byte load
        logic raw_cap;    // capture raw read data
        logic scan_init;  // start a rescan at the slot begin
        logic scan_begin; // start reading one counter
        logic scan_acc;   // take one counter byte
        logic scan_eval;  // judge one counter and step to the next start
        logic scan_done;  // commit the rescan result
        logic place;      // place a new record
        logic hdr_wr;     // write one header byte
        logic data_wr;    // write one user data byte
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;   // last byte of the clearing pass
        logic scan_more;  // another record start to examine
        logic acc_last;   // last counter byte
        logic hdr_last;   // last header byte
        logic need_start; // next append byte opens a record
        logic is_append;  // latched command is an append
    } t_ctl_sts;

    // Byte k of the filler pattern, little-endian.
    function automatic logic [7:0] filler_byte(input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = FILLER_WORD[7:0];
            2'd1:    b = FILLER_WORD[15:8];
            2'd2:    b = FILLER_WORD[23:16];
            default: b = FILLER_WORD[31:24];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/eclog_datapath.sv */
// Datapath of the circular log: byte store, configuration, scan and placement registers.
// Depends on eclog_pkg; driven by eclog_ctrl through t_ctl_cmd.
`default_nettype none

module eclog_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire eclog_pkg::t_ctl_cmd  i_cmd,
    output eclog_pkg::t_ctl_sts       o_sts,
    input  wire logic                 i_cfg_wr,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic [1:0]           i_command,
    input  wire logic [9:0]           i_address,
    input  wire logic [7:0]           i_data_byte,
    output logic [7:0]                o_read_byte,
    output logic [9:0]                o_record_position,
    output logic [31:0]               o_record_counter,
    output logic                      o_record_done
);

    localparam int AW = eclog_pkg::AW;

    // Configuration registers.
    logic [9:0]  r_slot_begin;
    logic [10:0] r_slot_length;
    logic [6:0]  r_user_bytes;
    logic [2:0]  r_counter_bytes;
    logic [15:0] r_counter_max;

    // Log state.
    logic [AW-1:0] r_last_start;
    logic [31:0]   r_last_cnt;
    logic [6:0]    r_bir;
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_clr;

    // Latched command.
    logic [1:0]    r_cmd;
    logic [AW-1:0] r_addr;
    logic [7:0]    r_db;
    logic [7:0]    r_rd;
    logic          r_done;

    // Scan registers.
    logic [11:0]   r_i;
    logic          r_first;
    logic [1:0]    r_k;
    logic [31:0]   r_c;
    logic [31:0]   r_prev;
    logic [AW-1:0] r_pos;
    logic [2:0]    r_hk;

    // Byte store.
    logic [7:0]    r_mem [eclog_pkg::STORE_BYTES];
    logic [7:0]    r_rd_data;

    // Effective sizes.
    logic [2:0]  cb_eff;
    logic [6:0]  ub_eff;
    logic [6:0]  rec_len;
    logic [11:0] slot_end;

    always_comb begin
        if (r_counter_bytes == 3'd0) begin
            cb_eff = 3'd1;
        end else if (r_counter_bytes > 3'd4) begin
            cb_eff = 3'd4;
        end else begin
            cb_eff = r_counter_bytes;
        end
        if (r_user_bytes == 7'd0) begin
            ub_eff = 7'd1;
        end else if (r_user_bytes > 7'(eclog_pkg::MAX_USER_BYTES)) begin
            ub_eff = 7'(eclog_pkg::MAX_USER_BYTES);
        end else begin
            ub_eff = r_user_bytes;
        end
        rec_len  = 7'({4'd0, cb_eff}) + 7'(eclog_pkg::CRC_BYTES) + ub_eff;
        slot_end = {2'd0, r_slot_begin} + {1'b0, r_slot_length};
    end

    // Placement arithmetic on the committed last record.
    logic [11:0] pl_start0;
    logic [11:0] pl_start;
    logic [31:0] pl_cnt;
    logic        pl_empty;

    always_comb begin
        pl_empty  = (r_last_start == r_slot_begin) && (r_last_cnt == 32'd0);
        pl_start0 = {2'd0, r_last_start} + (pl_empty ? 12'd0 : {5'd0, rec_len});
        pl_start  = ((pl_start0 + {5'd0, rec_len}) > slot_end) ? {2'd0, r_slot_begin}
                                                               : pl_start0;
        pl_cnt    = (r_last_cnt >= {16'd0, r_counter_max}) ? 32'd1 : r_last_cnt + 32'd1;
    end

    // Header byte: counter bytes first, then filler.
    logic [7:0] hdr_byte;
    logic [2:0] hdr_fk;

    always_comb begin
        hdr_fk = r_hk - cb_eff;
        if (r_hk < cb_eff) begin
            hdr_byte = 8'(r_last_cnt >> (8 * r_hk[1:0]));
        end else begin
            hdr_byte = eclog_pkg::filler_byte(hdr_fk[1:0]);
        end
    end

    // Store port selection.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [11:0]   scan_addr;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wp;
        wr_data = r_db;
        if (i_cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_data = 8'hFF;
        end else if (i_cmd.raw_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_addr;
        end else if (i_cmd.hdr_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_last_start + AW'(r_hk);
            wr_data = hdr_byte;
        end else if (i_cmd.data_wr) begin
            wr_en   = 1'b1;
        end
        scan_addr = r_i + {10'd0, r_k};
        rd_addr   = (r_cmd == eclog_pkg::CMD_READ) ? r_addr : scan_addr[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Status to the controller.
    logic [11:0] next_end;
    logic [2:0]  hdr_top;

    always_comb begin
        next_end         = r_i + {5'd0, rec_len};
        hdr_top          = cb_eff + 3'(eclog_pkg::CRC_BYTES - 1);
        o_sts.clr_last   = (r_clr == AW'(eclog_pkg::STORE_BYTES - 1));
        o_sts.scan_more  = r_first || (next_end <= slot_end);
        o_sts.acc_last   = ({1'b0, r_k} == cb_eff - 3'd1);
        o_sts.hdr_last   = (r_hk == hdr_top);
        o_sts.need_start = (r_bir == 7'd0);
        o_sts.is_append  = (r_cmd == eclog_pkg::CMD_APPEND);
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_begin    <= 10'd0;
            r_slot_length   <= 11'd1024;
            r_user_bytes    <= 7'd8;
            r_counter_bytes <= 3'd1;
            r_counter_max   <= 16'd255;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                eclog_pkg::CFG_SLOT_BEGIN:    r_slot_begin    <= i_cfg_data[9:0];
                eclog_pkg::CFG_SLOT_LENGTH:   r_slot_length   <= i_cfg_data[10:0];
                eclog_pkg::CFG_USER_BYTES:    r_user_bytes    <= i_cfg_data[6:0];
                eclog_pkg::CFG_COUNTER_BYTES: r_counter_bytes <= i_cfg_data[2:0];
                eclog_pkg::CFG_COUNTER_MAX:   r_counter_max   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Log state and clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_start <= '0;
            r_last_cnt   <= 32'd0;
            r_bir        <= 7'd0;
            r_wp         <= '0;
            r_clr        <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.scan_done) begin
                r_last_start <= r_pos;
                r_last_cnt   <= r_prev;
            end
            if (i_cmd.place) begin
                r_last_start <= pl_start[AW-1:0];
                r_last_cnt   <= pl_cnt;
                r_wp         <= AW'(pl_start + {9'd0, cb_eff}
                                    + 12'(eclog_pkg::CRC_BYTES));
            end
            if (i_cmd.data_wr) begin
                r_wp <= r_wp + AW'(1);
                if ((r_bir + 7'd1) >= ub_eff) begin
                    r_bir <= 7'd0;
                end else begin
                    r_bir <= r_bir + 7'd1;
                end
            end
        end
    end

    // Command capture, scan and header sequencing.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd  <= i_command;
            r_addr <= i_address[AW-1:0];
            r_db   <= i_data_byte;
            r_rd   <= 8'd0;
            r_done <= 1'b0;
        end
        if (i_cmd.raw_cap) begin
            r_rd <= r_rd_data;
        end
        if (i_cmd.data_wr) begin
            r_done <= ((r_bir + 7'd1) >= ub_eff);
        end
        if (i_cmd.scan_init) begin
            r_i     <= {2'd0, r_slot_begin};
            r_first <= 1'b1;
            r_pos   <= r_slot_begin;
        end
        if (i_cmd.scan_begin) begin
            r_k <= 2'd0;
            r_c <= 32'd0;
        end
        if (i_cmd.scan_acc) begin
            r_c <= r_c | ({24'd0, r_rd_data} << (8 * r_k));
            r_k <= r_k + 2'd1;
        end
        if (i_cmd.scan_eval) begin
            if (r_first || (r_c == r_prev + 32'd1)
                || ((r_c == 32'd1) && (r_prev == {16'd0, r_counter_max}))) begin
                r_prev <= r_c;
                r_pos  <= r_i[AW-1:0];
            end
            r_i     <= next_end;
            r_first <= 1'b0;
        end
        if (i_cmd.place) begin
            r_hk <= 3'd0;
        end
        if (i_cmd.hdr_wr) begin
            r_hk <= r_hk + 3'd1;
        end
    end

    // Result fields.
    assign o_read_byte       = r_rd;
    assign o_record_position = r_last_start;
    assign o_record_counter  = r_last_cnt;
    assign o_record_done     = r_done;

endmodule

`default_nettype wire

/* rtl/eclog_ctrl.sv */
// Controller state machine of the circular log.
// Depends on eclog_pkg; commands eclog_datapath through t_ctl_cmd.
`default_nettype none

module eclog_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [1:0]          i_command,
    input  wire eclog_pkg::t_ctl_sts i_sts,
    output eclog_pkg::t_ctl_cmd      o_cmd,
    output logic                     o_busy,
    output logic                     o_valid
);

    typedef enum logic [11:0] {
        S_CLEAR     = 12'b0000_0000_0001,
        S_IDLE      = 12'b0000_0000_0010,
        S_RAW_WR    = 12'b0000_0000_0100,
        S_RAW_RD    = 12'b0000_0000_1000,
        S_RAW_CAP   = 12'b0000_0001_0000,
        S_SCAN_CHK  = 12'b0000_0010_0000,
        S_SCAN_RD   = 12'b0000_0100_0000,
        S_SCAN_ACC  = 12'b0000_1000_0000,
        S_SCAN_EVAL = 12'b0001_0000_0000,
        S_PLACE     = 12'b0010_0000_0000,
        S_WR_HDR    = 12'b0100_0000_0000,
        S_WR_DATA   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    case (i_command)
                        eclog_pkg::CMD_LOAD: n_state = S_RAW_WR;
                        eclog_pkg::CMD_READ: n_state = S_RAW_RD;
                        eclog_pkg::CMD_APPEND: begin
                            if (i_sts.need_start) begin
                                o_cmd.scan_init = 1'b1;
                                n_state = S_SCAN_CHK;
                            end else begin
                                n_state = S_WR_DATA;
                            end
                        end
                        default: begin
                            o_cmd.scan_init = 1'b1;
                            n_state = S_SCAN_CHK;
                        end
                    endcase
                end
            end
            S_RAW_WR: begin
                o_cmd.raw_wr = 1'b1;
                n_valid      = 1'b1;
                n_state      = S_IDLE;
            end
            S_RAW_RD: begin
                n_state = S_RAW_CAP;
            end
            S_RAW_CAP: begin
                o_cmd.raw_cap = 1'b1;
                n_valid       = 1'b1;
                n_state       = S_IDLE;
            end
            S_SCAN_CHK: begin
                if (i_sts.scan_more) begin
                    o_cmd.scan_begin = 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    o_cmd.scan_done = 1'b1;
                    if (i_sts.is_append) begin
                        n_state = S_PLACE;
                    end else begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_ACC;
            end
            S_SCAN_ACC: begin
                o_cmd.scan_acc = 1'b1;
                n_state = i_sts.acc_last ? S_SCAN_EVAL : S_SCAN_RD;
            end
            S_SCAN_EVAL: begin
                o_cmd.scan_eval = 1'b1;
                n_state = S_SCAN_CHK;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state = S_WR_HDR;
            end
            S_WR_HDR: begin
                o_cmd.hdr_wr = 1'b1;
                if (i_sts.hdr_last) begin
                    n_state = S_WR_DATA;
                end
            end
            S_WR_DATA: begin
                o_cmd.data_wr = 1'b1;
                n_valid       = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result strobe registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* rtl/eeprom_circular_log_slot.sv */
// Top level of the wear-leveling circular log: controller plus datapath.
// Depends on eclog_pkg, eclog_ctrl and eclog_datapath.
//
//  Channel   Handshake                    Payload
//  ------    ---------------------------  ----------------------------------------
//  command   i_start & !o_busy            i_command, i_address, i_data_byte
//  result    o_valid, one cycle, no stall o_read_byte, o_record_position,
//                                         o_record_counter, o_record_done
//  config    i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// A load passes through S_RAW_WR, an append byte inside a record through S_WR_DATA and a
// read through S_RAW_RD and S_RAW_CAP before the result strobe. A rescan reads every
// counter byte of each record start in the slot through the single read port of the
// byte store; a record's first byte adds placement and the header writes to that.
// After reset all 1024 bytes of the store are erased to 0xFF while o_busy is high;
// configuration writes are taken at any time. The result strobe cannot be stalled.
`default_nettype none

module eeprom_circular_log_slot (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [9:0]  i_address,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    output logic [7:0]       o_read_byte,
    output logic [9:0]       o_record_position,
    output logic [31:0]      o_record_counter,
    output logic             o_record_done,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    eclog_pkg::t_ctl_cmd ctl_cmd;
    eclog_pkg::t_ctl_sts ctl_sts;

    // Configuration registers accept a transfer every cycle.
    assign o_cfg_ready = 1'b1;

    eclog_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_command),
        .i_sts     (ctl_sts),
        .o_cmd     (ctl_cmd),
        .o_busy    (o_busy),
        .o_valid   (o_valid)
    );

    eclog_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (ctl_cmd),
        .o_sts             (ctl_sts),
        .i_cfg_wr          (i_cfg_valid & o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_command         (i_command),
        .i_address         (i_address),
        .i_data_byte       (i_data_byte),
        .o_read_byte       (o_read_byte),
        .o_record_position (o_record_position),
        .o_record_counter  (o_record_counter),
        .o_record_done     (o_record_done)
    );

endmodule

`default_nettype wire

/* rtl/eclog_checker.sv */
// Port-level checks of the circular log top level, attached by bind.
// Depends only on the ports of eeprom_circular_log_slot.
`default_nettype none

module eclog_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic        o_valid,
    input wire logic [7:0]  o_read_byte,
    input wire logic        o_record_done
);

    // A transfer in always makes the block busy next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after accepting a command");

    // The result strobe lasts exactly one cycle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // The result comes once the work is over, with the block idle.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe while busy");

    // Record completion comes only with an append result, which reads nothing.
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_record_done && o_valid |-> (o_read_byte == 8'd0))
        else $error("record completion with a read byte");

endmodule

bind eeprom_circular_log_slot eclog_checker u_eclog_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_valid       (o_valid),
    .o_read_byte   (o_read_byte),
    .o_record_done (o_record_done)
);

`default_nettype wire
